[hw/rtl/tes_pkg.sv]
// Shared types and constants for the text encoding sniffer.
package tes_pkg;

  localparam int ByteW = 8;
  localparam int EncW  = 4;
  localparam int BomW  = 3;
  localparam int CntW  = 3;
  localparam int LeadN = 4;

  localparam logic [CntW-1:0] SeenMax = 3'd5;

  localparam logic [EncW-1:0] ENC_ANSI    = 4'd0;
  localparam logic [EncW-1:0] ENC_WIN1252 = 4'd1;
  localparam logic [EncW-1:0] ENC_UTF8    = 4'd2;
  localparam logic [EncW-1:0] ENC_UTF16BE = 4'd3;
  localparam logic [EncW-1:0] ENC_UTF16LE = 4'd4;
  localparam logic [EncW-1:0] ENC_UTF32BE = 4'd5;
  localparam logic [EncW-1:0] ENC_UTF32LE = 4'd6;
  localparam logic [EncW-1:0] ENC_SCSU    = 4'd7;
  localparam logic [EncW-1:0] ENC_BOCU1   = 4'd8;

  // Allowed range of the next continuation byte.
  typedef enum logic [2:0] {
    RNG_80_BF = 3'd0,
    RNG_A0_BF = 3'd1,
    RNG_80_9F = 3'd2,
    RNG_90_BF = 3'd3,
    RNG_80_8F = 3'd4
  } range_kind_t;

  // Validator verdict handed to the BOM/result logic.
  typedef struct packed {
    logic invalid;   // blob fails strict UTF-8, truncation included
  } u8_status_t;

endpackage

[hw/rtl/tes_utf8_check.sv]
// Strict UTF-8 validator: one byte per enable, clears on the last byte.
module tes_utf8_check (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [tes_pkg::ByteW-1:0]  data,
  input  logic                       last,
  output tes_pkg::u8_status_t        status
);

  logic [1:0]           cont;
  logic [1:0]           cont_next;
  tes_pkg::range_kind_t kind;
  tes_pkg::range_kind_t kind_next;
  logic                 invalid;
  logic                 invalid_next;
  logic                 zero_seen;
  logic                 zero_seen_next;
  logic                 cont_ok;

  always_comb begin
    case (kind)
      tes_pkg::RNG_A0_BF: cont_ok = (data inside {[8'ha0:8'hbf]});
      tes_pkg::RNG_80_9F: cont_ok = (data inside {[8'h80:8'h9f]});
      tes_pkg::RNG_90_BF: cont_ok = (data inside {[8'h90:8'hbf]});
      tes_pkg::RNG_80_8F: cont_ok = (data inside {[8'h80:8'h8f]});
      default:            cont_ok = (data inside {[8'h80:8'hbf]});
    endcase
  end

  always_comb begin
    cont_next      = cont;
    kind_next      = kind;
    invalid_next   = invalid;
    zero_seen_next = zero_seen;
    if (!invalid && !zero_seen) begin
      if (cont != 2'd0) begin
        if (!cont_ok) begin
          invalid_next = 1'b1;
        end else begin
          cont_next = cont - 2'd1;
          kind_next = tes_pkg::RNG_80_BF;
        end
      end else if (data == 8'h00) begin
        zero_seen_next = 1'b1;
      end else if (data inside {8'h09, 8'h0a, 8'h0d, [8'h20:8'h7e]}) begin
        // plain ASCII
      end else if (data inside {[8'hc2:8'hdf]}) begin
        cont_next = 2'd1;
        kind_next = tes_pkg::RNG_80_BF;
      end else if (data == 8'he0) begin
        cont_next = 2'd2;
        kind_next = tes_pkg::RNG_A0_BF;
      end else if (data == 8'hed) begin
        cont_next = 2'd2;
        kind_next = tes_pkg::RNG_80_9F;
      end else if (data inside {[8'he1:8'hef]}) begin
        cont_next = 2'd2;
        kind_next = tes_pkg::RNG_80_BF;
      end else if (data == 8'hf0) begin
        cont_next = 2'd3;
        kind_next = tes_pkg::RNG_90_BF;
      end else if (data inside {[8'hf1:8'hf3]}) begin
        cont_next = 2'd3;
        kind_next = tes_pkg::RNG_80_BF;
      end else if (data == 8'hf4) begin
        cont_next = 2'd3;
        kind_next = tes_pkg::RNG_80_8F;
      end else begin
        invalid_next = 1'b1;
      end
    end
  end

  // A sequence cut short by the end of the blob is invalid.
  assign status.invalid = invalid_next | (!zero_seen_next && (cont_next != 2'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      cont      <= 2'd0;
      kind      <= tes_pkg::RNG_80_BF;
      invalid   <= 1'b0;
      zero_seen <= 1'b0;
    end else if (en) begin
      if (last) begin
        cont      <= 2'd0;
        kind      <= tes_pkg::RNG_80_BF;
        invalid   <= 1'b0;
        zero_seen <= 1'b0;
      end else begin
        cont      <= cont_next;
        kind      <= kind_next;
        invalid   <= invalid_next;
        zero_seen <= zero_seen_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_zero_no_pending: assert property (@(posedge clk) disable iff (rst)
    zero_seen |-> cont == 2'd0)
    else $error("zero byte stop with continuation pending");

  a_kind_needs_cont: assert property (@(posedge clk) disable iff (rst)
    kind != tes_pkg::RNG_80_BF |-> cont >= 2'd2)
    else $error("narrow range kind without a lead byte pending");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    en && last |=> cont == 2'd0 && !invalid && !zero_seen)
    else $error("validator state not cleared after last byte");
`endif

endmodule

[hw/rtl/text_encoding_sniffer_top.sv]
// Top level of the text encoding sniffer: BOM check, UTF-8 verdict, result register.
//
//  channel | signals                          | moves
//  --------+----------------------------------+--------------------------------
//  in      | in_valid in_ready data_byte      | one blob byte per transaction
//          | last_byte                        |
//  out     | out_valid out_ready              | one result per blob, after its
//          | encoding_code bom_length         | last byte
//
// One byte per cycle sustained: a byte sits in the input register while the
// validator and BOM compare update, then the result register takes the verdict
// of a last byte. Reset clears the valid flags and the blob and validator state;
// a last byte returns that blob and validator state to its reset value.
// in_ready drops only while a last byte waits for a result register still held
// by out_ready low; ordinary bytes never stall.
module text_encoding_sniffer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tes_pkg::ByteW-1:0]   data_byte,
  input  logic                        last_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tes_pkg::EncW-1:0]    encoding_code,
  output logic [tes_pkg::BomW-1:0]    bom_length
);

  logic                       s1_valid;
  logic [tes_pkg::ByteW-1:0]  s1_byte;
  logic                       s1_last;
  logic                       adv;

  logic [tes_pkg::CntW-1:0]   bytes_seen;
  logic [tes_pkg::CntW-1:0]   bytes_seen_next;
  logic [tes_pkg::ByteW-1:0]  lead [tes_pkg::LeadN];
  logic [tes_pkg::ByteW-1:0]  lead_next [tes_pkg::LeadN];
  logic                       high_seen;
  logic                       high_seen_next;

  tes_pkg::u8_status_t        u8_status;

  logic                       m_utf8, m_16be, m_16le, m_32be, m_32le, m_scsu, m_bocu;
  logic [tes_pkg::EncW-1:0]   enc_next;
  logic [tes_pkg::BomW-1:0]   bom_next;

  // A last byte advances only when the result register is free.
  assign adv      = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  tes_utf8_check u_utf8 (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .data   (s1_byte),
    .last   (s1_last),
    .status (u8_status)
  );

  assign bytes_seen_next = (bytes_seen == tes_pkg::SeenMax) ? bytes_seen
                                                            : bytes_seen + 3'd1;
  assign high_seen_next  = high_seen | s1_byte[tes_pkg::ByteW-1];

  always_comb begin
    for (int i = 0; i < tes_pkg::LeadN; i++) begin
      lead_next[i] = (bytes_seen == 3'(i)) ? s1_byte : lead[i];
    end
  end

  always_comb begin
    m_utf8 = (bytes_seen_next >= 3'd3) && lead_next[0] == 8'hef &&
             lead_next[1] == 8'hbb && lead_next[2] == 8'hbf;
    m_16be = (bytes_seen_next >= 3'd2) && lead_next[0] == 8'hfe && lead_next[1] == 8'hff;
    m_16le = (bytes_seen_next >= 3'd2) && lead_next[0] == 8'hff && lead_next[1] == 8'hfe;
    m_32be = (bytes_seen_next >= 3'd4) && lead_next[0] == 8'h00 &&
             lead_next[1] == 8'h00 && lead_next[2] == 8'hfe && lead_next[3] == 8'hff;
    m_32le = (bytes_seen_next >= 3'd4) && lead_next[0] == 8'hff &&
             lead_next[1] == 8'hfe && lead_next[2] == 8'h00 && lead_next[3] == 8'h00;
    m_scsu = (bytes_seen_next >= 3'd3) && lead_next[0] == 8'h0e &&
             lead_next[1] == 8'hfe && lead_next[2] == 8'hff;
    m_bocu = (bytes_seen_next >= 3'd3) && lead_next[0] == 8'hfb &&
             lead_next[1] == 8'hee && lead_next[2] == 8'h28;
  end

  always_comb begin
    bom_next = 3'd0;
    if (m_utf8) begin
      enc_next = tes_pkg::ENC_UTF8;    bom_next = 3'd3;
    end else if (m_16be) begin
      enc_next = tes_pkg::ENC_UTF16BE; bom_next = 3'd2;
    end else if (m_16le) begin
      enc_next = tes_pkg::ENC_UTF16LE; bom_next = 3'd2;
    end else if (m_32be) begin
      enc_next = tes_pkg::ENC_UTF32BE; bom_next = 3'd4;
    end else if (m_32le) begin
      enc_next = tes_pkg::ENC_UTF32LE; bom_next = 3'd4;
    end else if (m_scsu) begin
      enc_next = tes_pkg::ENC_SCSU;    bom_next = 3'd3;
    end else if (m_bocu) begin
      enc_next = tes_pkg::ENC_BOCU1;   bom_next = 3'd3;
    end else if (!u8_status.invalid) begin
      enc_next = tes_pkg::ENC_UTF8;
    end else if (high_seen_next) begin
      enc_next = tes_pkg::ENC_WIN1252;
    end else begin
      enc_next = tes_pkg::ENC_ANSI;
    end
  end

  // Advance blob state; drop it back to reset on the last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= 3'd0;
      high_seen  <= 1'b0;
      for (int i = 0; i < tes_pkg::LeadN; i++) lead[i] <= 8'h00;
    end else if (adv) begin
      if (s1_last) begin
        bytes_seen <= 3'd0;
        high_seen  <= 1'b0;
        for (int i = 0; i < tes_pkg::LeadN; i++) lead[i] <= 8'h00;
      end else begin
        bytes_seen <= bytes_seen_next;
        high_seen  <= high_seen_next;
        for (int i = 0; i < tes_pkg::LeadN; i++) lead[i] <= lead_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last) begin
      encoding_code <= enc_next;
      bom_length    <= bom_next;
    end
  end

`ifndef SYNTHESIS
  a_bom_implies_marked: assert property (@(posedge clk) disable iff (rst)
    out_valid && bom_length != 3'd0 |-> encoding_code >= tes_pkg::ENC_UTF8)
    else $error("bom length with an unmarked encoding");

  a_no_bom_plain: assert property (@(posedge clk) disable iff (rst)
    out_valid && bom_length == 3'd0 |-> encoding_code <= tes_pkg::ENC_UTF8)
    else $error("marked encoding without bom length");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    adv && s1_last |=> out_valid && bytes_seen == 3'd0)
    else $error("last byte did not produce a result or clear state");

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= tes_pkg::SeenMax)
    else $error("byte count past saturation");
`endif

endmodule
